// ===== rtl/core/cone_membership_test_assert.svh =====
// Assertion macros used by the cone membership test top level.
// Each macro clocks on aclk and is disabled while aresetn is low.
`ifndef CONE_MEMBERSHIP_TEST_ASSERT_SVH
`define CONE_MEMBERSHIP_TEST_ASSERT_SVH
`ifndef ASSERT_OFF
`define CMT_ASSERT_IMPL(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define CMT_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) pre |=> post) else $error(msg);
`else
`define CMT_ASSERT_IMPL(label, prop, msg)
`define CMT_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

// ===== rtl/core/cmt_pkg.sv =====
package cmt_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int ANGLE_BITS_DEF = 16;
    localparam int SCALE_SHIFT    = 24;
    localparam int CORDIC_ITERS   = 32;
    localparam int Z_BITS         = 32;
    localparam int GAIN_BITS      = 25;
    localparam int PADDR_BITS     = 5;
    localparam int AXIS_X_RESET   = 1000;

    // CORDIC gain in Q24, used to scale the opposite side of a ratio angle.
    localparam logic [GAIN_BITS-1:0] GAIN_Q24 = 25'd27628053;
    localparam logic [Z_BITS-1:0]    HALF_TURN_Z = 32'h8000_0000;

    typedef enum logic [2:0] {
        REG_APEX_X      = 3'd0,
        REG_APEX_Y      = 3'd1,
        REG_AXIS_X      = 3'd2,
        REG_AXIS_Y      = 3'd3,
        REG_CONE_RADIUS = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic cd_zero;
        logic rad_zero;
        logic pt_zero;
        logic mar_zero;
    } flags_t;

    localparam int FLAGS_BITS = $bits(flags_t);

    // Elementary angles atan(2^-i) in 32-bit binary units.
    function automatic logic [Z_BITS-1:0] atan_entry(input logic [4:0] idx);
        logic [Z_BITS-1:0] val;
        case (idx)
            5'd0:  val = 32'h20000000;
            5'd1:  val = 32'h12E4051E;
            5'd2:  val = 32'h09FB385B;
            5'd3:  val = 32'h051111D4;
            5'd4:  val = 32'h028B0D43;
            5'd5:  val = 32'h0145D7E1;
            5'd6:  val = 32'h00A2F61E;
            5'd7:  val = 32'h00517C55;
            5'd8:  val = 32'h0028BE53;
            5'd9:  val = 32'h00145F2F;
            5'd10: val = 32'h000A2F98;
            5'd11: val = 32'h000517CC;
            5'd12: val = 32'h00028BE6;
            5'd13: val = 32'h000145F3;
            5'd14: val = 32'h0000A2FA;
            5'd15: val = 32'h0000517D;
            5'd16: val = 32'h000028BE;
            5'd17: val = 32'h0000145F;
            5'd18: val = 32'h00000A30;
            5'd19: val = 32'h00000518;
            5'd20: val = 32'h0000028C;
            5'd21: val = 32'h00000146;
            5'd22: val = 32'h000000A3;
            5'd23: val = 32'h00000051;
            5'd24: val = 32'h00000029;
            5'd25: val = 32'h00000014;
            5'd26: val = 32'h0000000A;
            5'd27: val = 32'h00000005;
            5'd28: val = 32'h00000003;
            5'd29: val = 32'h00000001;
            5'd30: val = 32'h00000001;
            default: val = 32'h00000000;
        endcase
        return val;
    endfunction

endpackage

// ===== rtl/core/cmt_front.sv =====
module cmt_front #(
    parameter int CB = cmt_pkg::COORD_BITS_DEF,
    parameter int W  = cmt_pkg::COORD_BITS_DEF + 28
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic signed [CB-1:0] apex_x,
    input  logic signed [CB-1:0] apex_y,
    input  logic signed [CB-1:0] axis_x,
    input  logic signed [CB-1:0] axis_y,
    input  logic        [CB-2:0] cone_radius,
    input  logic signed [CB-1:0] point_x,
    input  logic signed [CB-1:0] point_y,
    input  logic        [CB-2:0] margin,
    output logic signed [W-1:0]  cdx_s,
    output logic signed [W-1:0]  cdy_s,
    output logic signed [W-1:0]  pdx_s,
    output logic signed [W-1:0]  pdy_s,
    output logic signed [W-1:0]  rad_g,
    output logic signed [W-1:0]  mar_g,
    output cmt_pkg::flags_t      flags
);
    import cmt_pkg::*;

    logic signed [CB:0] cdx, cdy, pdx, pdy;
    logic [CB+GAIN_BITS-2:0] rad_prod, mar_prod;
    flags_t flags_next;

    logic signed [W-1:0] cdx_reg, cdy_reg, pdx_reg, pdy_reg, rad_g_reg, mar_g_reg;
    flags_t flags_reg;

    assign cdx = (CB+1)'(axis_x) - (CB+1)'(apex_x);
    assign cdy = (CB+1)'(axis_y) - (CB+1)'(apex_y);
    assign pdx = (CB+1)'(point_x) - (CB+1)'(apex_x);
    assign pdy = (CB+1)'(point_y) - (CB+1)'(apex_y);
    assign rad_prod = (CB+GAIN_BITS-1)'(cone_radius) * (CB+GAIN_BITS-1)'(GAIN_Q24);
    assign mar_prod = (CB+GAIN_BITS-1)'(margin) * (CB+GAIN_BITS-1)'(GAIN_Q24);

    always_comb begin
        flags_next.cd_zero  = (cdx == '0) && (cdy == '0);
        flags_next.rad_zero = (cone_radius == '0);
        flags_next.pt_zero  = (pdx == '0) && (pdy == '0);
        flags_next.mar_zero = (margin == '0);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cdx_reg   <= W'(cdx) <<< SCALE_SHIFT;
            cdy_reg   <= W'(cdy) <<< SCALE_SHIFT;
            pdx_reg   <= W'(pdx) <<< SCALE_SHIFT;
            pdy_reg   <= W'(pdy) <<< SCALE_SHIFT;
            rad_g_reg <= W'(rad_prod);
            mar_g_reg <= W'(mar_prod);
            flags_reg <= flags_next;
        end
    end

    assign cdx_s = cdx_reg;
    assign cdy_s = cdy_reg;
    assign pdx_s = pdx_reg;
    assign pdy_s = pdy_reg;
    assign rad_g = rad_g_reg;
    assign mar_g = mar_g_reg;
    assign flags = flags_reg;

endmodule

// ===== rtl/core/cmt_cordic.sv =====
module cmt_cordic #(
    parameter int W  = cmt_pkg::COORD_BITS_DEF + 28,
    parameter int SB = 1
) (
    input  logic                         aclk,
    input  logic                         en,
    input  logic signed [W-1:0]          x_in,
    input  logic signed [W-1:0]          y_in,
    input  logic        [SB-1:0]         sb_in,
    output logic signed [W-1:0]          x_out,
    output logic        [cmt_pkg::Z_BITS-1:0] z_out,
    output logic        [SB-1:0]         sb_out
);
    import cmt_pkg::*;

    logic signed [W-1:0]      x_reg  [0:CORDIC_ITERS];
    logic signed [W-1:0]      y_reg  [0:CORDIC_ITERS];
    logic        [Z_BITS-1:0] z_reg  [0:CORDIC_ITERS];
    logic        [SB-1:0]     sb_reg [0:CORDIC_ITERS];

    // Vectors in the left half plane are turned by a half turn first.
    always_ff @(posedge aclk) begin
        if (en) begin
            if (x_in[W-1]) begin
                x_reg[0] <= -x_in;
                y_reg[0] <= -y_in;
                z_reg[0] <= HALF_TURN_Z;
            end else begin
                x_reg[0] <= x_in;
                y_reg[0] <= y_in;
                z_reg[0] <= '0;
            end
            sb_reg[0] <= sb_in;
        end
    end

    for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
        logic signed [W-1:0] xs, ys;
        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;

        always_ff @(posedge aclk) begin
            if (en) begin
                if (!y_reg[i][W-1]) begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    z_reg[i+1] <= z_reg[i] + atan_entry(5'(i));
                end else begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    z_reg[i+1] <= z_reg[i] - atan_entry(5'(i));
                end
                sb_reg[i+1] <= sb_reg[i];
            end
        end
    end

    assign x_out  = x_reg[CORDIC_ITERS];
    assign z_out  = z_reg[CORDIC_ITERS];
    assign sb_out = sb_reg[CORDIC_ITERS];

endmodule

// ===== rtl/core/cmt_decide.sv =====
module cmt_decide #(
    parameter int AB = cmt_pkg::ANGLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [cmt_pkg::Z_BITS-1:0]    z_half,
    input  logic [cmt_pkg::Z_BITS-1:0]    z_extra,
    input  logic [AB-1:0]                 tha_q,
    input  logic [AB-1:0]                 thp_q,
    input  cmt_pkg::flags_t               flags,
    output logic                          in_cone
);
    import cmt_pkg::*;

    localparam logic [Z_BITS-1:0] RND = Z_BITS'(1) << (Z_BITS - 1 - AB);
    localparam logic [AB:0]       HALF_TURN = (AB+1)'(1) << (AB - 1);
    localparam logic [AB-1:0]     QUARTER   = AB'(1) << (AB - 2);

    logic [Z_BITS-1:0] zh_rnd, ze_rnd;
    logic [AB-1:0] half, extra, tha, diff;
    logic [AB:0] diff_abs, limit;
    logic inside_next, inside_reg;

    always_comb begin
        zh_rnd = z_half + RND;
        ze_rnd = z_extra + RND;
        if (flags.rad_zero) begin
            half = '0;
        end else if (flags.cd_zero) begin
            half = QUARTER;
        end else begin
            half = zh_rnd[Z_BITS-1 -: AB];
        end
        extra = flags.mar_zero ? '0 : ze_rnd[Z_BITS-1 -: AB];
        tha = flags.cd_zero ? '0 : tha_q;
        diff = thp_q - tha;
        // Fold the wrapped difference into the range zero to a half turn.
        if ({1'b0, diff} > HALF_TURN) begin
            diff_abs = (AB+1)'(1) << AB;
            diff_abs = diff_abs - {1'b0, diff};
        end else begin
            diff_abs = {1'b0, diff};
        end
        limit = {1'b0, half} + {1'b0, extra};
        if (flags.pt_zero) begin
            inside_next = !flags.mar_zero;
        end else begin
            inside_next = (diff_abs < limit);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            inside_reg <= inside_next;
        end
    end

    assign in_cone = inside_reg;

endmodule

// ===== rtl/core/cone_membership_test.sv =====
// Cone membership test. A transfer on the s_ channel carries a point and a
// clearance margin in millimetres; for every such transfer exactly one
// transfer leaves on the m_ channel, in order, with m_inside_res high when the
// angle between the point direction and the cone axis, seen from the apex, is
// strictly below the cone half angle plus atan(margin / distance). The cone
// (apex, axis point, base radius) is set through the APB port and must only
// be rewritten while no transfer is in flight. A point at the apex is inside
// only with a nonzero margin; a zero radius gives a zero half angle and an
// axis point on the apex with a nonzero radius gives a quarter turn. The
// block accepts one point per clock while no result is held at the output;
// the pipeline is a front stage, two chained 33-stage vectoring CORDIC
// pipelines (direction and distance, then the ratio angles) and a compare stage.
// The whole pipeline holds while a finished result waits on m_ready low.
`include "cone_membership_test_assert.svh"

module cone_membership_test #(
    parameter int COORD_BITS = cmt_pkg::COORD_BITS_DEF,
    parameter int ANGLE_BITS = cmt_pkg::ANGLE_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cmt_pkg::PADDR_BITS-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [COORD_BITS-1:0]   s_point_x,
    input  logic signed [COORD_BITS-1:0]   s_point_y,
    input  logic        [COORD_BITS-2:0]   s_margin,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_inside_res
);
    import cmt_pkg::*;

    // Datapath width: scaled coordinate difference plus CORDIC growth.
    localparam int W   = COORD_BITS + 28;
    localparam int LAT = 2 * (CORDIC_ITERS + 1) + 2;
    localparam logic [Z_BITS-1:0] RND = Z_BITS'(1) << (Z_BITS - 1 - ANGLE_BITS);

    logic signed [COORD_BITS-1:0] apex_x_reg, apex_y_reg, axis_x_reg, axis_y_reg;
    logic        [COORD_BITS-2:0] cone_radius_reg;
    logic                         cfg_wr;
    reg_idx_t                     cfg_idx;

    logic en;
    logic [LAT-1:0] valid_reg;

    logic signed [W-1:0] cdx_s, cdy_s, pdx_s, pdy_s, rad_g, mar_g;
    flags_t flags_f;

    logic signed [W-1:0] magc, magp, x2h_unused_sink, x2e_unused_sink;
    logic [Z_BITS-1:0] z_axis, z_point, z_half, z_extra;
    logic [W+FLAGS_BITS-1:0] sb_axis;
    logic [W-1:0] sb_point;
    logic [Z_BITS-1:0] z_axis_rnd, z_point_rnd;
    logic [ANGLE_BITS+FLAGS_BITS-1:0] sb_half;
    logic [ANGLE_BITS-1:0] sb_extra;
    flags_t flags_d;
    logic in_cone;

    // Configuration port. Writes complete in the access phase.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[PADDR_BITS-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            apex_x_reg      <= '0;
            apex_y_reg      <= '0;
            axis_x_reg      <= COORD_BITS'(AXIS_X_RESET);
            axis_y_reg      <= '0;
            cone_radius_reg <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_APEX_X:      apex_x_reg      <= pwdata[COORD_BITS-1:0];
                REG_APEX_Y:      apex_y_reg      <= pwdata[COORD_BITS-1:0];
                REG_AXIS_X:      axis_x_reg      <= pwdata[COORD_BITS-1:0];
                REG_AXIS_Y:      axis_y_reg      <= pwdata[COORD_BITS-1:0];
                REG_CONE_RADIUS: cone_radius_reg <= pwdata[COORD_BITS-2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_APEX_X:      prdata = 32'(unsigned'(apex_x_reg));
            REG_APEX_Y:      prdata = 32'(unsigned'(apex_y_reg));
            REG_AXIS_X:      prdata = 32'(unsigned'(axis_x_reg));
            REG_AXIS_Y:      prdata = 32'(unsigned'(axis_y_reg));
            REG_CONE_RADIUS: prdata = 32'(cone_radius_reg);
            default:         prdata = '0;
        endcase
    end

    // The whole pipeline moves together; it holds only when the output
    // register carries a result that has not been taken yet.
    assign en      = !valid_reg[LAT-1] || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[LAT-2:0], s_valid};
        end
    end

    cmt_front #(.CB(COORD_BITS), .W(W)) u_front (
        .aclk        (aclk),
        .en          (en),
        .apex_x      (apex_x_reg),
        .apex_y      (apex_y_reg),
        .axis_x      (axis_x_reg),
        .axis_y      (axis_y_reg),
        .cone_radius (cone_radius_reg),
        .point_x     (s_point_x),
        .point_y     (s_point_y),
        .margin      (s_margin),
        .cdx_s       (cdx_s),
        .cdy_s       (cdy_s),
        .pdx_s       (pdx_s),
        .pdy_s       (pdy_s),
        .rad_g       (rad_g),
        .mar_g       (mar_g),
        .flags       (flags_f)
    );

    // First pass: direction angle and CORDIC-scaled length of both vectors.
    cmt_cordic #(.W(W), .SB(W + FLAGS_BITS)) u_cordic_axis (
        .aclk   (aclk),
        .en     (en),
        .x_in   (cdx_s),
        .y_in   (cdy_s),
        .sb_in  ({rad_g, flags_f}),
        .x_out  (magc),
        .z_out  (z_axis),
        .sb_out (sb_axis)
    );

    cmt_cordic #(.W(W), .SB(W)) u_cordic_point (
        .aclk   (aclk),
        .en     (en),
        .x_in   (pdx_s),
        .y_in   (pdy_s),
        .sb_in  (mar_g),
        .x_out  (magp),
        .z_out  (z_point),
        .sb_out (sb_point)
    );

    // Direction angles are rounded to the output angle width here.
    assign z_axis_rnd  = z_axis + RND;
    assign z_point_rnd = z_point + RND;

    // Second pass: half angle atan(radius / length) and margin angle.
    cmt_cordic #(.W(W), .SB(ANGLE_BITS + FLAGS_BITS)) u_cordic_half (
        .aclk   (aclk),
        .en     (en),
        .x_in   (magc),
        .y_in   (sb_axis[W+FLAGS_BITS-1:FLAGS_BITS]),
        .sb_in  ({z_axis_rnd[Z_BITS-1 -: ANGLE_BITS], sb_axis[FLAGS_BITS-1:0]}),
        .x_out  (x2h_unused_sink),
        .z_out  (z_half),
        .sb_out (sb_half)
    );

    cmt_cordic #(.W(W), .SB(ANGLE_BITS)) u_cordic_extra (
        .aclk   (aclk),
        .en     (en),
        .x_in   (magp),
        .y_in   (sb_point),
        .sb_in  (z_point_rnd[Z_BITS-1 -: ANGLE_BITS]),
        .x_out  (x2e_unused_sink),
        .z_out  (z_extra),
        .sb_out (sb_extra)
    );

    assign flags_d = flags_t'(sb_half[FLAGS_BITS-1:0]);

    cmt_decide #(.AB(ANGLE_BITS)) u_decide (
        .aclk    (aclk),
        .en      (en),
        .z_half  (z_half),
        .z_extra (z_extra),
        .tha_q   (sb_half[ANGLE_BITS+FLAGS_BITS-1:FLAGS_BITS]),
        .thp_q   (sb_extra),
        .flags   (flags_d),
        .in_cone (in_cone)
    );

    assign m_valid      = valid_reg[LAT-1];
    assign m_inside_res = in_cone;

    // The input side only stalls behind an untaken result.
    `CMT_ASSERT_IMPL(a_stall_cause, !s_ready |-> (m_valid && !m_ready), "input stalled without a blocked result")
    // An accepted transfer occupies the first pipeline slot on the next edge.
    `CMT_ASSERT_NEXT(a_accept_enters, s_valid && s_ready, valid_reg[0], "accepted transfer lost at entry")
    // A held pipeline keeps its result in place.
    `CMT_ASSERT_NEXT(a_hold_result, m_valid && !m_ready, m_valid && $stable(in_cone), "held result changed")

endmodule

// ===== tb/cone_membership_checker.sv =====
module cone_membership_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic                           pready,
    input  logic [cmt_pkg::PADDR_BITS-1:0] paddr,
    input  logic [31:0]                    pwdata,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic signed [15:0]             s_point_x,
    input  logic signed [15:0]             s_point_y,
    input  logic        [14:0]             s_margin,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic                           m_inside_res,
    output int                             fail_count,
    output int                             inside_pending
);
    import cmt_pkg::*;

    localparam int ABITS = 16;
    localparam longint SCALE = 64'sd1 << 24;
    localparam longint GAIN = 64'sd27628053;

    logic [31:0] elem_angle [32];
    logic signed [15:0] apex_x_q, apex_y_q, axis_x_q, axis_y_q;
    logic [14:0] radius_q;
    bit inside_fifo [$];

    initial begin
        elem_angle = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
                       32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
                       32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
                       32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
                       32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
                       32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
                       32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
                       32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000};
        fail_count = 0;
        inside_pending = 0;
    end

    // Vectoring rotation; returns the 32-bit direction and the scaled length.
    function automatic logic [31:0] vector_angle(input longint x0, input longint y0,
                                                 output longint len);
        longint x, y, xs, ys;
        logic [31:0] z;
        x = x0;
        y = y0;
        z = '0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
        end
        for (int i = 0; i < 32; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + elem_angle[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - elem_angle[i];
            end
        end
        len = x;
        return z;
    endfunction

    function automatic logic [31:0] to_bam(input logic [31:0] z);
        logic [31:0] r;
        r = (z + 32'h0000_8000) >> (32 - ABITS);
        return r & 32'h0000_FFFF;
    endfunction

    function automatic bit predict_inside(input logic signed [15:0] px,
                                          input logic signed [15:0] py,
                                          input logic [14:0] mar);
        longint cdx, cdy, pdx, pdy, len_c, len_p, unused;
        logic [31:0] axis_dir, pt_dir, half, extra, diff;
        cdx = longint'(axis_x_q) - longint'(apex_x_q);
        cdy = longint'(axis_y_q) - longint'(apex_y_q);
        pdx = longint'(px) - longint'(apex_x_q);
        pdy = longint'(py) - longint'(apex_y_q);
        axis_dir = '0;
        extra = '0;
        len_c = 0;
        if (cdx != 0 || cdy != 0)
            axis_dir = to_bam(vector_angle(cdx * SCALE, cdy * SCALE, len_c));
        if (radius_q == 0)
            half = '0;
        else if (cdx == 0 && cdy == 0)
            half = 32'h1 << (ABITS - 2);
        else
            half = to_bam(vector_angle(len_c, longint'(radius_q) * GAIN, unused));
        if (pdx == 0 && pdy == 0)
            return mar != 0;
        pt_dir = to_bam(vector_angle(pdx * SCALE, pdy * SCALE, len_p));
        if (mar != 0)
            extra = to_bam(vector_angle(len_p, longint'(mar) * GAIN, unused));
        diff = (pt_dir - axis_dir) & 32'h0000_FFFF;
        if (diff > (32'h1 << (ABITS - 1)))
            diff = (32'h1 << ABITS) - diff;
        return diff < half + extra;
    endfunction

    always @(posedge aclk) begin
        bit want;
        if (!aresetn) begin
            apex_x_q <= '0;
            apex_y_q <= '0;
            axis_x_q <= 16'sd1000;
            axis_y_q <= '0;
            radius_q <= '0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr >> 2)
                    REG_APEX_X:      apex_x_q <= pwdata[15:0];
                    REG_APEX_Y:      apex_y_q <= pwdata[15:0];
                    REG_AXIS_X:      axis_x_q <= pwdata[15:0];
                    REG_AXIS_Y:      axis_y_q <= pwdata[15:0];
                    REG_CONE_RADIUS: radius_q <= pwdata[14:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                inside_fifo.push_back(predict_inside(s_point_x, s_point_y, s_margin));
            if (m_valid && m_ready) begin
                if (inside_fifo.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual inside_res=%0b",
                             $time, m_inside_res);
                    fail_count++;
                end else begin
                    want = inside_fifo.pop_front();
                    if (m_inside_res !== want) begin
                        $display("%0t: inside_res mismatch, expected %0b, actual %0b",
                                 $time, want, m_inside_res);
                        fail_count++;
                    end
                end
            end
            inside_pending = inside_fifo.size();
        end
    end
endmodule

// ===== tb/cone_membership_test_tb.sv =====
module cone_membership_test_tb;
    import cmt_pkg::*;

    // Pipeline depth is 68; we drain with some slack before touching config.
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT = 400000;
    localparam int UNMAPPED_REG = 5;
    localparam int RAND_PER_PHASE = 580;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [PADDR_BITS-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [15:0] s_point_x = '0, s_point_y = '0;
    logic [14:0] s_margin = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_inside_res;

    int fail_count, inside_pending;
    int send_idle_pct, recv_idle_pct;
    int cycle_cnt;
    bit hold_request;
    logic s_fire;

    // Current cone, kept here so random points can be aimed near its axis.
    logic signed [15:0] cur_apex_x, cur_apex_y, cur_axis_x, cur_axis_y;

    always #5 aclk = ~aclk;

    cone_membership_test u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_point_x(s_point_x), .s_point_y(s_point_y), .s_margin(s_margin),
        .m_valid(m_valid), .m_ready(m_ready), .m_inside_res(m_inside_res)
    );

    cone_membership_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_point_x(s_point_x), .s_point_y(s_point_y), .s_margin(s_margin),
        .m_valid(m_valid), .m_ready(m_ready), .m_inside_res(m_inside_res),
        .fail_count(fail_count), .inside_pending(inside_pending)
    );

    // The transfer flag is captured with pre-edge values, so the sender can
    // look at it on the following falling edge without any race.
    always @(posedge aclk) s_fire <= s_valid && s_ready;

    // Watchdog: a hung handshake must not hang the run.
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver. A hold request makes it drop ready for a long stretch that it
    // counts on its own, long enough for the pipeline to fill and push back.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Setup, access, then idle, so consecutive writes never touch
    // the same control signal twice in one step.
    task automatic apb_write(input int idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_BITS'(idx * 4);
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_cone(input logic signed [15:0] ax, input logic signed [15:0] ay,
                            input logic signed [15:0] bx, input logic signed [15:0] by,
                            input logic [14:0] rad);
        apb_write(REG_APEX_X, {16'h0, ax});
        apb_write(REG_APEX_Y, {16'h0, ay});
        apb_write(REG_AXIS_X, {16'h0, bx});
        apb_write(REG_AXIS_Y, {16'h0, by});
        apb_write(REG_CONE_RADIUS, {17'h0, rad});
        cur_apex_x = ax;
        cur_apex_y = ay;
        cur_axis_x = bx;
        cur_axis_y = by;
    endtask

    // Holds valid high across back-to-back transfers; each step assigns once.
    task automatic send_point(input logic signed [15:0] px, input logic signed [15:0] py,
                              input logic [14:0] mar);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_point_x <= px;
        s_point_y <= py;
        s_margin <= mar;
        do @(negedge aclk); while (!s_fire);
    endtask

    // Sender pauses until every result is back, then the pipe is left to empty.
    task automatic drain();
        s_valid <= 1'b0;
        while (inside_pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    function automatic logic [14:0] rand_margin();
        case ($urandom_range(3))
            0: return '0;
            1: return 15'($urandom_range(200));
            default: return 15'($urandom);
        endcase
    endfunction

    // Mostly points scattered around the axis direction so that the strict
    // compare near the cone edge is exercised; the rest cover the full range.
    task automatic send_random_point();
        logic signed [15:0] px, py;
        int k;
        if ($urandom_range(2) == 0) begin
            px = 16'($urandom);
            py = 16'($urandom);
        end else begin
            k = $urandom_range(8) + 1;
            px = cur_apex_x + 16'((int'(cur_axis_x) - int'(cur_apex_x)) * k / 4)
                 + 16'($urandom_range(400)) - 16'sd200;
            py = cur_apex_y + 16'((int'(cur_axis_y) - int'(cur_apex_y)) * k / 4)
                 + 16'($urandom_range(400)) - 16'sd200;
        end
        send_point(px, py, rand_margin());
    endtask

    task automatic random_cone();
        logic signed [15:0] ax, ay;
        ax = 16'($urandom_range(4000)) - 16'sd2000;
        ay = 16'($urandom_range(4000)) - 16'sd2000;
        if ($urandom_range(3) == 0)
            set_cone(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     15'($urandom));
        else
            set_cone(ax, ay, ax + 16'($urandom_range(6000)) - 16'sd3000,
                     ay + 16'($urandom_range(6000)) - 16'sd3000,
                     15'($urandom_range(3000)));
    endtask

    initial begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        cycle_cnt = 0;
        hold_request = 1'b0;
        cur_apex_x = '0;
        cur_apex_y = '0;
        cur_axis_x = 16'sd1000;
        cur_axis_y = '0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset cone: zero radius, so a point counts as inside only through its margin,
        // plus the apex point with and without margin.
        send_point(16'sd2000, 16'sd0, 15'd0);
        send_point(16'sd0, 16'sd0, 15'd0);
        send_point(16'sd0, 16'sd0, 15'd1);
        send_point(16'sd500, 16'sd100, 15'd200);
        // Exactly opposite the axis: a half turn of difference.
        send_point(-16'sd1000, 16'sd0, 15'd32767);
        send_point(-16'sd1000, 16'sd0, 15'd0);
        drain();

        // Widest cone offset and field extremes.
        set_cone(-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768, 15'd32767);
        apb_write(UNMAPPED_REG, 32'hFFFF_FFFF);
        send_point(16'sd32767, -16'sd32768, 15'd0);
        send_point(-16'sd32768, 16'sd32767, 15'd32767);
        send_point(-16'sd32768, 16'sd32767, 15'd0);
        send_point(16'sd32767, 16'sd32767, 15'd32767);
        send_point(-16'sd32768, -16'sd32768, 15'd1);
        send_point(16'sd0, 16'sd0, 15'd16384);
        drain();

        // Axis point on the apex: the half angle becomes a quarter turn.
        set_cone(16'sd100, -16'sd100, 16'sd100, -16'sd100, 15'd5);
        send_point(16'sd200, -16'sd100, 15'd0);
        send_point(16'sd100, 16'sd900, 15'd0);
        send_point(16'sd100, -16'sd100, 15'd0);
        send_point(-16'sd900, -16'sd100, 15'd0);
        send_point(-16'sd900, -16'sd99, 15'd0);
        drain();

        // Same degenerate axis with zero radius, at a point with and without margin.
        set_cone(16'sd100, -16'sd100, 16'sd100, -16'sd100, 15'd0);
        send_point(16'sd200, -16'sd100, 15'd0);
        send_point(16'sd200, -16'sd100, 15'd10);
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 51 : 0;
            recv_idle_pct = (phase == 0) ? 51 : (phase == 1) ? 7 : 0;
            random_cone();
            // The long receiver stall lands in the phase without idling so
            // the sender keeps offering and the input gets pushed back.
            if (phase == 2)
                hold_request = 1'b1;
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                send_random_point();
                if (n == RAND_PER_PHASE / 2) begin
                    drain();
                    random_cone();
                end
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/cmt_pkg.sv
rtl/core/cmt_front.sv
rtl/core/cmt_cordic.sv
rtl/core/cmt_decide.sv
rtl/core/cone_membership_test.sv
tb/cone_membership_checker.sv
tb/cone_membership_test_tb.sv
